// ===== hw/rtl/bwr_pkg.sv =====
package bwr_pkg;

    // Widths of the item fields
    localparam int WORD_W   = 32;
    localparam int BASE_W   = 18;
    localparam int OFFSET_W = 19;

    // Internal widths: shift count, base before saturation and offset sum before saturation
    localparam int CNT_W   = 7;
    localparam int BWIDE_W = BASE_W + 1;
    localparam int SUM_W   = OFFSET_W + 1;

    // Saturation limit of the base and of the offset
    localparam logic [BASE_W-1:0] BASE_MAX = 18'h3ffff;

    // Shift-and-test steps the shared unit takes per cycle
    localparam int STEPS = 4;

    // Commands from the sequencer to the shift unit
    typedef enum logic [2:0] {
        OP_IDLE    = 3'd0,
        OP_LOAD    = 3'd1,
        OP_ALIGN   = 3'd2,
        OP_FIT     = 3'd3,
        OP_MERGE   = 3'd4,
        OP_COMPACT = 3'd5,
        OP_FINISH  = 3'd6
    } op_t;

    typedef struct packed {
        op_t  op;
        logic first;
    } unit_cmd_t;

    typedef struct packed {
        logic                       aligned;
        logic                       fits;
        logic                       low_free;
        logic signed [OFFSET_W-1:0] offset;
        logic        [BASE_W-1:0]   base;
    } unit_stat_t;

endpackage

// ===== hw/rtl/bwr_in_if.sv =====
interface bwr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] bitmap_word;
    logic        first_in_block;
    logic        last_in_block;
    logic        new_round;

    modport source (
        output valid, bitmap_word, first_in_block, last_in_block, new_round,
        input  ready
    );
    modport sink (
        input  valid, bitmap_word, first_in_block, last_in_block, new_round,
        output ready
    );
endinterface

// ===== hw/rtl/bwr_out_if.sv =====
interface bwr_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] rename_offset;
    logic               offset_valid;
    logic        [17:0] max_base;

    modport source (
        output valid, rename_offset, offset_valid, max_base,
        input  ready
    );
    modport sink (
        input  valid, rename_offset, offset_valid, max_base,
        output ready
    );
endinterface

// ===== hw/rtl/bwr_shift_unit.sv =====
module bwr_shift_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bwr_pkg::unit_cmd_t              cmd,
    input  logic [bwr_pkg::WORD_W-1:0]      word,
    output bwr_pkg::unit_stat_t             stat
);

    logic        [bwr_pkg::WORD_W-1:0]   w_reg, w_next;
    logic        [bwr_pkg::WORD_W-1:0]   win_reg, win_next;
    logic signed [bwr_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic        [bwr_pkg::BWIDE_W-1:0]  b_reg, b_next;
    logic signed [bwr_pkg::OFFSET_W-1:0] off_reg, off_next;
    logic signed [bwr_pkg::SUM_W-1:0]    off_sum;
    logic signed [bwr_pkg::OFFSET_W-1:0] off_sat;
    logic        [bwr_pkg::BASE_W-1:0]   base_sat;

    // Offset = shift count + base, clipped at the top
    always_comb
    begin
        off_sum = bwr_pkg::SUM_W'(cnt_reg) + bwr_pkg::SUM_W'($signed({1'b0, b_reg}));
        if (off_sum > $signed({2'b00, bwr_pkg::BASE_MAX}))
            off_sat = $signed({1'b0, bwr_pkg::BASE_MAX});
        else
            off_sat = off_sum[bwr_pkg::OFFSET_W-1:0];
    end

    // Clip the base
    always_comb
    begin
        if (b_reg > {1'b0, bwr_pkg::BASE_MAX})
            base_sat = bwr_pkg::BASE_MAX;
        else
            base_sat = b_reg[bwr_pkg::BASE_W-1:0];
    end

    // Run the commanded phase: load, up to STEPS guarded steps of align, fit or compact, merge or finish
    always_comb
    begin
        w_next   = w_reg;
        win_next = win_reg;
        cnt_next = cnt_reg;
        b_next   = b_reg;
        off_next = off_reg;
        case (cmd.op)
            bwr_pkg::OP_LOAD:
            begin
                w_next   = word;
                cnt_next = '0;
                if (cmd.first)
                begin
                    win_next = '0;
                    b_next   = bwr_pkg::BWIDE_W'(1);
                end
            end
            bwr_pkg::OP_ALIGN:
            begin
                for (int k = 0; k < bwr_pkg::STEPS; k++)
                begin
                    if (!w_next[0])
                    begin
                        w_next   = w_next >> 1;
                        cnt_next = cnt_next - bwr_pkg::CNT_W'(1);
                    end
                end
            end
            bwr_pkg::OP_FIT:
            begin
                for (int k = 0; k < bwr_pkg::STEPS; k++)
                begin
                    if ((win_next & w_next) != '0)
                    begin
                        if (!w_next[bwr_pkg::WORD_W-1])
                        begin
                            w_next   = w_next << 1;
                            cnt_next = cnt_next + bwr_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            win_next = win_next >> 1;
                            b_next   = b_next + bwr_pkg::BWIDE_W'(1);
                        end
                    end
                end
            end
            bwr_pkg::OP_MERGE:
            begin
                win_next = win_reg | w_reg;
                off_next = off_sat;
            end
            bwr_pkg::OP_COMPACT:
            begin
                for (int k = 0; k < bwr_pkg::STEPS; k++)
                begin
                    if (win_next[0])
                    begin
                        win_next = win_next >> 1;
                        b_next   = b_next + bwr_pkg::BWIDE_W'(1);
                    end
                end
            end
            bwr_pkg::OP_FINISH:
            begin
                b_next = {1'b0, base_sat};
            end
            default:
            begin
            end
        endcase
    end

    // Window and base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            b_reg   <= bwr_pkg::BWIDE_W'(1);
        end
        else
        begin
            win_reg <= win_next;
            b_reg   <= b_next;
        end
    end

    // Word, shift count and offset
    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        cnt_reg <= cnt_next;
        off_reg <= off_next;
    end

    assign stat.aligned  = w_reg[0];
    assign stat.fits     = ((win_reg & w_reg) == '0);
    assign stat.low_free = !win_reg[0];
    assign stat.offset   = off_reg;
    assign stat.base     = base_sat;

endmodule

// ===== hw/rtl/bitmap_window_renamer.sv =====
// A zero word goes from acceptance straight to the finish state; a nonzero word passes
//   through the align, fit, merge, compact and finish states in that order, the shared
//   shift unit doing four steps per cycle. Finish waits until the output register is free.
// Throughput: one item at a time; the next item is accepted once the result is
//   written to the output register. Reset clears window, base (to one) and maximum.
module bitmap_window_renamer (
    input  logic         clk,
    input  logic         rst_n,
    bwr_in_if.sink       word_in,
    bwr_out_if.source    rename_out
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_ALIGN   = 6'b000010,
        ST_FIT     = 6'b000100,
        ST_MERGE   = 6'b001000,
        ST_COMPACT = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    bwr_pkg::unit_cmd_t                  cmd;
    bwr_pkg::unit_stat_t                 stat;
    logic                                in_acc;
    logic                                out_free;
    logic                                finish_fire;
    logic                                nonzero_reg, nonzero_next;
    logic                                last_reg, last_next;
    logic [bwr_pkg::BASE_W-1:0]          max_reg, max_next, max_upd;
    logic                                out_valid_reg, out_valid_next;
    logic signed [bwr_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic                                offset_valid_reg, offset_valid_next;
    logic [bwr_pkg::BASE_W-1:0]          max_base_reg, max_base_next;

    bwr_shift_unit u_shift (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .word  (word_in.bitmap_word),
        .stat  (stat)
    );

    assign word_in.ready = (state_reg == ST_IDLE);
    assign in_acc        = word_in.valid && word_in.ready;
    assign out_free      = !out_valid_reg || rename_out.ready;
    assign finish_fire   = (state_reg == ST_FINISH) && out_free;

    // Sequence the shift unit through the phases of one item
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = bwr_pkg::OP_IDLE;
        cmd.first    = 1'b0;
        nonzero_next = nonzero_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd.op       = bwr_pkg::OP_LOAD;
                    cmd.first    = word_in.first_in_block;
                    nonzero_next = (word_in.bitmap_word != '0);
                    last_next    = word_in.last_in_block;
                    state_next   = (word_in.bitmap_word != '0) ? ST_ALIGN : ST_FINISH;
                end
            end
            ST_ALIGN:
            begin
                if (stat.aligned)
                    state_next = ST_FIT;
                else
                    cmd.op = bwr_pkg::OP_ALIGN;
            end
            ST_FIT:
            begin
                if (stat.fits)
                    state_next = ST_MERGE;
                else
                    cmd.op = bwr_pkg::OP_FIT;
            end
            ST_MERGE:
            begin
                cmd.op     = bwr_pkg::OP_MERGE;
                state_next = ST_COMPACT;
            end
            ST_COMPACT:
            begin
                if (stat.low_free)
                    state_next = ST_FINISH;
                else
                    cmd.op = bwr_pkg::OP_COMPACT;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.op     = bwr_pkg::OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Fold the block-final base into the running maximum; a new round clears it
    always_comb
    begin
        max_upd = max_reg;
        if (last_reg && (stat.base > max_reg))
            max_upd = stat.base;
        max_next = max_reg;
        if (in_acc && word_in.new_round)
            max_next = '0;
        else if (finish_fire)
            max_next = max_upd;
    end

    // Hold the result until taken; load it when an item finishes
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        offset_next       = offset_reg;
        offset_valid_next = offset_valid_reg;
        max_base_next     = max_base_reg;
        if (rename_out.ready)
            out_valid_next = 1'b0;
        if (finish_fire)
        begin
            out_valid_next    = 1'b1;
            offset_next       = nonzero_reg ? stat.offset : '0;
            offset_valid_next = nonzero_reg;
            max_base_next     = max_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nonzero_reg      <= nonzero_next;
        last_reg         <= last_next;
        offset_reg       <= offset_next;
        offset_valid_reg <= offset_valid_next;
        max_base_reg     <= max_base_next;
    end

    assign rename_out.valid         = out_valid_reg;
    assign rename_out.rename_offset = offset_reg;
    assign rename_out.offset_valid  = offset_valid_reg;
    assign rename_out.max_base      = max_base_reg;

`ifndef SYNTHESIS
    // A zero word skips the shift phases
    a_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (word_in.bitmap_word == '0)) |=> (state_reg == ST_FINISH))
        else $error("zero word did not go straight to finish");

    // The word must be collision free when merged
    a_merge_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> stat.fits)
        else $error("merge with a colliding window");

    // After compaction the lowest window bit is free
    a_compacted: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && nonzero_reg) |-> stat.low_free)
        else $error("window not compacted at finish");

    // A result without a valid offset carries a zero offset
    a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !offset_valid_reg) |-> (offset_reg == '0))
        else $error("nonzero offset on a zero word");
`endif

endmodule

// ===== tb/bwr_tb_pkg.sv =====
package bwr_tb_pkg;

    import bwr_pkg::*;

    // One expected output item of the renamer
    typedef struct packed {
        logic signed [OFFSET_W-1:0] rename_offset;
        logic                       offset_valid;
        logic        [BASE_W-1:0]   max_base;
    } rename_result_t;

    class rename_scoreboard;

        bit [63:0]      window;
        int             base;
        int             max_seen;
        rename_result_t pending_renames[$];
        int             errors;

        function new();
            window   = '0;
            base     = 1;
            max_seen = 0;
            errors   = 0;
        endfunction

        // Predict the output item for one accepted bitmap word and queue it
        function void note_word(bit [WORD_W-1:0] word, bit first, bit last, bit fresh);
            bit [63:0]      w;
            int             shift;
            int             b;
            rename_result_t r;
            r = '0;
            if (fresh)
                max_seen = 0;
            if (first)
            begin
                window = '0;
                base   = 1;
            end
            if (word != '0)
            begin
                w     = {32'b0, word};
                shift = 0;
                // align lowest set bit to window bit 0
                while (w[0] == 1'b0)
                begin
                    w = w >> 1;
                    shift--;
                end
                b = base;
                // move the word up until it clears the occupied bits
                while ((window & w) != '0 && w[31] == 1'b0)
                begin
                    w = w << 1;
                    shift++;
                end
                // word at the top and still colliding: slide the window instead
                while ((window & w) != '0)
                begin
                    window = window >> 1;
                    b++;
                end
                shift = shift + b;
                if (shift > int'(BASE_MAX))
                    shift = int'(BASE_MAX);
                r.rename_offset = shift[OFFSET_W-1:0];
                r.offset_valid  = 1'b1;
                // merge, then drop the run of occupied low bits
                window = window | w;
                while (window[0] == 1'b1)
                begin
                    window = window >> 1;
                    b++;
                end
                if (b > int'(BASE_MAX))
                    b = int'(BASE_MAX);
                base = b;
            end
            if (last && base > max_seen)
                max_seen = base;
            r.max_base = max_seen[BASE_W-1:0];
            pending_renames.push_back(r);
        endfunction

        // Compare one output item with the oldest prediction
        function void check_result(time stamp, logic signed [OFFSET_W-1:0] offset,
                                   logic offset_valid, logic [BASE_W-1:0] max_base);
            rename_result_t want;
            if (pending_renames.size() == 0)
            begin
                $display("%0d ns: unexpected item, offset %0d offset_valid %0b max_base %0d",
                         stamp, offset, offset_valid, max_base);
                errors++;
                return;
            end
            want = pending_renames.pop_front();
            if (offset !== want.rename_offset)
            begin
                $display("%0d ns: rename_offset expected %0d, actual %0d",
                         stamp, want.rename_offset, offset);
                errors++;
            end
            if (offset_valid !== want.offset_valid)
            begin
                $display("%0d ns: offset_valid expected %0b, actual %0b",
                         stamp, want.offset_valid, offset_valid);
                errors++;
            end
            if (max_base !== want.max_base)
            begin
                $display("%0d ns: max_base expected %0d, actual %0d",
                         stamp, want.max_base, max_base);
                errors++;
            end
        endfunction

        function int pending();
            return pending_renames.size();
        endfunction

        // Flag every prediction that never got its output item
        function void flush_missing(time stamp);
            rename_result_t want;
            while (pending_renames.size() != 0)
            begin
                want = pending_renames.pop_front();
                $display("%0d ns: missing item, expected offset %0d offset_valid %0b max_base %0d",
                         stamp, want.rename_offset, want.offset_valid, want.max_base);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== tb/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bwr_pkg::*;
    import bwr_tb_pkg::*;

    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 60;
    localparam int RANDOM_ITEMS    = 1250;

    logic clk;
    logic rst_n;

    bwr_in_if  word_in_if ();
    bwr_out_if rename_out_if ();

    bitmap_window_renamer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_in    (word_in_if),
        .rename_out (rename_out_if)
    );

    rename_scoreboard sb = new();

    bit no_idle;
    int hold_off_req;
    int hold_off_seen;
    int stall_left;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Output side: random ready, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rename_out_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (hold_off_seen != hold_off_req)
        begin
            hold_off_seen <= hold_off_req;
            stall_left <= HOLD_OFF_CYCLES;
            rename_out_if.ready <= 1'b0;
        end
        else
            rename_out_if.ready <= no_idle || ($urandom_range(99) >= 7);
    end

    // Check every accepted output item
    always @(posedge clk)
    begin
        if (rst_n && rename_out_if.valid && rename_out_if.ready)
            sb.check_result($time, rename_out_if.rename_offset,
                            rename_out_if.offset_valid, rename_out_if.max_base);
    end

    // Offer one word, hold it until accepted, then predict its output item
    task automatic send_word(bit [31:0] word, bit first, bit last, bit fresh);
        while (!no_idle && $urandom_range(99) < 7)
        begin
            word_in_if.valid <= 1'b0;
            @(negedge clk);
        end
        word_in_if.valid          <= 1'b1;
        word_in_if.bitmap_word    <= word;
        word_in_if.first_in_block <= first;
        word_in_if.last_in_block  <= last;
        word_in_if.new_round      <= fresh;
        @(posedge clk);
        while (!word_in_if.ready)
            @(posedge clk);
        sb.note_word(word, first, last, fresh);
        @(negedge clk);
    endtask

    // Drop valid before any pause of the sender
    task automatic rest_sender();
        word_in_if.valid <= 1'b0;
    endtask

    // Mix of word shapes: empty, full, sparse, runs, top bit, dense
    function automatic bit [31:0] rand_word();
        bit [31:0] w;
        int        len;
        w = '0;
        case ($urandom_range(9))
            0: w = '0;
            1: w = 32'hFFFF_FFFF;
            2, 3:
            begin
                w = 32'h1 << $urandom_range(31);
                if ($urandom_range(1) == 1)
                    w = w | (32'h1 << $urandom_range(31));
            end
            4:
            begin
                len = $urandom_range(32, 1);
                w = (len == 32) ? 32'hFFFF_FFFF : ((32'h1 << len) - 1);
                w = w << $urandom_range(31);
            end
            5: w = 32'h8000_0000 | ($urandom() >> $urandom_range(31, 1));
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // Run out of time: fail
    initial
    begin
        #30_000_000;
        $display("FAIL bitmap_window_renamer");
        $finish;
    end

    initial
    begin
        int  sent;
        int  len;
        int  waited;
        bit  broken;
        bit  first;
        bit  last;
        bit  fresh;
        bit  pressed;

        no_idle                     = 1'b0;
        hold_off_req                = 0;
        hold_off_seen               = 0;
        stall_left                  = 0;
        pressed                     = 1'b0;
        sent                        = 0;
        rst_n                       = 1'b0;
        word_in_if.valid            = 1'b0;
        word_in_if.bitmap_word      = '0;
        word_in_if.first_in_block   = 1'b0;
        word_in_if.last_in_block    = 1'b0;
        word_in_if.new_round        = 1'b0;
        rename_out_if.ready         = 1'b0;

        // Hold reset, release at a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: no block start after reset, zero words, top bit only,
        // shift to fit, window slide, dense patterns, one-word blocks
        send_word(32'h0000_0001, 1'b0, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b1, 1'b0);
        send_word(32'h8000_0000, 1'b1, 1'b0, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_word(32'h0000_0005, 1'b1, 1'b0, 1'b0);
        send_word(32'h0000_0003, 1'b0, 1'b0, 1'b0);
        send_word(32'h8000_0001, 1'b0, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_word(32'h5555_5555, 1'b0, 1'b0, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0);
        send_word(32'hFFFF_0000, 1'b0, 1'b1, 1'b0);
        send_word(32'h0000_FFFF, 1'b1, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b1, 1'b1);
        send_word(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
        send_word(32'h8000_0001, 1'b0, 1'b0, 1'b0);
        send_word(32'hC000_0003, 1'b0, 1'b0, 1'b0);
        send_word(32'h0001_0001, 1'b0, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b1, 1'b1);
        send_word(32'hDEAD_BEEF, 1'b1, 1'b1, 1'b0);
        send_word(32'h0000_0002, 1'b1, 1'b1, 1'b0);

        // Random blocks: mostly well framed, some with broken framing
        while (sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
            broken = ($urandom_range(9) < 2);
            for (int k = 0; k < len; k++)
            begin
                // quiet stretch with no idling on either side
                no_idle = (sent >= 300 && sent < 600);
                // long output hold-off while words keep coming
                if (!pressed && sent >= 800)
                begin
                    pressed = 1'b1;
                    hold_off_req <= hold_off_req + 1;
                end
                if (broken)
                begin
                    first = ($urandom_range(3) == 0);
                    last  = ($urandom_range(3) == 0);
                    fresh = ($urandom_range(3) == 0);
                end
                else
                begin
                    first = (k == 0);
                    last  = (k == len - 1);
                    fresh = (k == 0) && ($urandom_range(4) == 0);
                end
                send_word(rand_word(), first, last, fresh);
                sent++;
            end
        end
        no_idle = 1'b0;

        // Close out with words that continue the current window, then a one-word block that starts a new round
        send_word(32'h0000_0005, 1'b0, 1'b0, 1'b0);
        send_word(32'h0000_0003, 1'b0, 1'b1, 1'b0);
        for (int k = 0; k < 40; k++)
            send_word(rand_word(), 1'b0, ($urandom_range(7) == 0), 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b1, 1'b0);
        send_word(rand_word(), 1'b1, 1'b1, 1'b1);
        rest_sender();

        // Drain, then give late items a chance to show up
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.flush_missing($time);

        if (sb.errors == 0)
            $display("PASS bitmap_window_renamer");
        else
            $display("FAIL bitmap_window_renamer");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bwr_pkg.sv
hw/rtl/bwr_in_if.sv
hw/rtl/bwr_out_if.sv
hw/rtl/bwr_shift_unit.sv
hw/rtl/bitmap_window_renamer.sv
tb/bwr_tb_pkg.sv
tb/tb_top.sv
